/* src/pskf_pkg.sv */
package pskf_pkg;

    localparam int STAGES    = 6;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam int LIFE_W    = 24;
    localparam int DIM_W     = 16;
    localparam int TIME_W    = 16;
    localparam int AGE_W     = 13;
    localparam int FQUO_W    = 12;
    localparam int NUM_W     = 28;

    localparam int FDIV_N    = FQUO_W;
    localparam int BDIV_N    = NUM_W;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CW      = 3;

    localparam logic [AGE_W-1:0] AGE_ONE = 13'd4096;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_keys;

    typedef struct packed {
        logic              zero_tot;
        logic              over;
        logic [LIFE_W-1:0] rem;
        logic [LIFE_W-1:0] tot;
        logic [FQUO_W-1:0] quo;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
    } t_fdiv;

    typedef struct packed {
        logic              applied;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [AGE_W-1:0]  age;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [DIM_W-1:0]  s0;
        logic [DIM_W-1:0]  s1;
    } t_mid;

    typedef struct packed {
        logic              applied;
        logic              use_s1;
        logic              neg;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  s0;
        logic [DIM_W-1:0]  s1;
        logic [TIME_W-1:0] d;
        logic [NUM_W-1:0]  num;
        logic [TIME_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
    } t_bdiv;

    typedef struct packed {
        logic [DIM_W-1:0] width_new;
        logic [DIM_W-1:0] height_new;
        logic             segment_applied;
    } t_result;

    function automatic logic [CFG_W-1:0] key_rst(input int k);
        key_rst = 32'h10000100 + CFG_W'(k) * 32'h10000000;
    endfunction

endpackage

/* src/pskf_midq.sv */
module pskf_midq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pskf_pkg::t_mid i_data,
    output logic          o_full,
    input  logic          i_pop,
    output pskf_pkg::t_mid o_data,
    output logic          o_empty
);
    import pskf_pkg::*;

    t_mid            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

/* src/pskf_front.sv */
module pskf_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pskf_pkg::t_keys                        i_keys,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [pskf_pkg::LIFE_W-1:0]            i_life_remaining,
    input  logic [pskf_pkg::LIFE_W-1:0]            i_life_total,
    input  logic [pskf_pkg::DIM_W-1:0]             i_width_now,
    input  logic [pskf_pkg::DIM_W-1:0]             i_height_now,
    output logic                                   o_mid_push,
    output pskf_pkg::t_mid                         o_mid_data,
    input  logic                                   i_mid_full
);
    import pskf_pkg::*;

    logic             r_dv [FDIV_N+1];
    t_fdiv            r_ds [FDIV_N+1];
    t_fdiv            n_ds [FDIV_N+1];

    logic             r_av;
    logic [AGE_W-1:0] r_age;
    logic [DIM_W-1:0] r_aw;
    logic [DIM_W-1:0] r_ah;
    logic [AGE_W-1:0] n_age;

    logic             f_adv;

    function automatic t_fdiv fdiv_step(input t_fdiv s);
        t_fdiv               o;
        logic [LIFE_W:0]     t;
        logic [LIFE_W:0]     diff;
        logic                ge;
        o    = s;
        t    = {s.rem, 1'b0};
        diff = t - {1'b0, s.tot};
        ge   = (t >= {1'b0, s.tot});
        o.rem = ge ? diff[LIFE_W-1:0] : t[LIFE_W-1:0];
        o.quo = {s.quo[FQUO_W-2:0], ge};
        return o;
    endfunction

    assign f_adv  = !r_av || !i_mid_full;
    assign o_full = !f_adv;

    always_comb begin
        n_ds[0].zero_tot = (i_life_total == '0);
        n_ds[0].over     = (i_life_remaining >= i_life_total);
        n_ds[0].rem      = i_life_remaining;
        n_ds[0].tot      = i_life_total;
        n_ds[0].quo      = '0;
        n_ds[0].w        = i_width_now;
        n_ds[0].h        = i_height_now;
        for (int k = 0; k < FDIV_N; k++) begin
            n_ds[k+1] = fdiv_step(r_ds[k]);
        end
    end

    always_comb begin
        if (r_ds[FDIV_N].zero_tot) begin
            n_age = AGE_ONE;
        end else if (r_ds[FDIV_N].over) begin
            n_age = '0;
        end else begin
            n_age = AGE_ONE - {1'b0, r_ds[FDIV_N].quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FDIV_N; k++) r_dv[k] <= 1'b0;
            r_av <= 1'b0;
        end else if (f_adv) begin
            r_dv[0] <= i_push;
            for (int k = 0; k < FDIV_N; k++) r_dv[k+1] <= r_dv[k];
            r_av <= r_dv[FDIV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            for (int k = 0; k <= FDIV_N; k++) r_ds[k] <= n_ds[k];
            r_age <= n_age;
            r_aw  <= r_ds[FDIV_N].w;
            r_ah  <= r_ds[FDIV_N].h;
        end
    end

    always_comb begin
        logic [CFG_IDX_W-1:0] seg;
        logic [CFG_IDX_W-1:0] seg1;
        logic                 found;
        seg   = '0;
        found = 1'b0;
        for (int j = 0; j < STAGES - 1; j++) begin
            if ({3'b0, r_age} >= i_keys[j][CFG_W-1:DIM_W]) begin
                seg   = CFG_IDX_W'(j);
                found = 1'b1;
            end
        end
        seg1 = seg + 1'b1;
        o_mid_data.applied = found;
        o_mid_data.w       = r_aw;
        o_mid_data.h       = r_ah;
        o_mid_data.age     = r_age;
        o_mid_data.t0      = i_keys[seg][CFG_W-1:DIM_W];
        o_mid_data.t1      = i_keys[seg1][CFG_W-1:DIM_W];
        o_mid_data.s0      = i_keys[seg][DIM_W-1:0];
        o_mid_data.s1      = i_keys[seg1][DIM_W-1:0];
    end

    assign o_mid_push = r_av && !i_mid_full;

endmodule

/* src/pskf_back.sv */
module pskf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pskf_pkg::t_mid              i_mid_data,
    input  logic                        i_mid_empty,
    output logic                        o_mid_pop,
    output logic [pskf_pkg::DIM_W-1:0]  o_width_new,
    output logic [pskf_pkg::DIM_W-1:0]  o_height_new,
    output logic                        o_segment_applied,
    output logic                        o_empty,
    input  logic                        i_pop
);
    import pskf_pkg::*;

    logic            r_bv [BDIV_N+1];
    t_bdiv           r_bs [BDIV_N+1];
    t_bdiv           n_bs [BDIV_N+1];

    t_result         r_oq [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    t_result         res;
    logic            b_adv;
    logic            oq_full;
    logic            oq_push;
    logic            oq_pop;

    function automatic t_bdiv bdiv_step(input t_bdiv s);
        t_bdiv             o;
        logic [TIME_W:0]   t;
        logic [TIME_W:0]   diff;
        logic              ge;
        o    = s;
        t    = {s.rem, s.num[NUM_W-1]};
        diff = t - {1'b0, s.d};
        ge   = (t >= {1'b0, s.d});
        o.rem = ge ? diff[TIME_W-1:0] : t[TIME_W-1:0];
        o.num = {s.num[NUM_W-2:0], 1'b0};
        o.quo = {s.quo[NUM_W-2:0], ge};
        return o;
    endfunction

    assign oq_full   = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign b_adv     = !r_bv[BDIV_N] || !oq_full;
    assign o_mid_pop = b_adv && !i_mid_empty;
    assign oq_push   = b_adv && r_bv[BDIV_N];
    assign oq_pop    = i_pop && !o_empty;

    always_comb begin
        logic [TIME_W:0]          d17;
        logic [DIM_W:0]           diff17;
        logic [DIM_W-1:0]         mag;
        logic [AGE_W-1:0]         da;
        logic [DIM_W+AGE_W-1:0]   prod;
        logic                     use_s1;
        d17    = {1'b0, i_mid_data.t1} - {1'b0, i_mid_data.t0};
        use_s1 = d17[TIME_W] || (d17 == '0);
        diff17 = {1'b0, i_mid_data.s1} - {1'b0, i_mid_data.s0};
        mag    = diff17[DIM_W] ? DIM_W'(-diff17) : diff17[DIM_W-1:0];
        da     = i_mid_data.age - i_mid_data.t0[AGE_W-1:0];
        prod   = {{AGE_W{1'b0}}, mag} * {{DIM_W{1'b0}}, da};
        n_bs[0].applied = i_mid_data.applied;
        n_bs[0].use_s1  = use_s1;
        n_bs[0].neg     = diff17[DIM_W];
        n_bs[0].w       = i_mid_data.w;
        n_bs[0].h       = i_mid_data.h;
        n_bs[0].s0      = i_mid_data.s0;
        n_bs[0].s1      = i_mid_data.s1;
        n_bs[0].d       = use_s1 ? TIME_W'(1) : d17[TIME_W-1:0];
        n_bs[0].num     = prod[NUM_W-1:0];
        n_bs[0].rem     = '0;
        n_bs[0].quo     = '0;
        for (int k = 0; k < BDIV_N; k++) begin
            n_bs[k+1] = bdiv_step(r_bs[k]);
        end
    end

    always_comb begin
        logic [NUM_W+1:0]    qadj;
        logic [NUM_W+1:0]    qs;
        logic signed [NUM_W+2:0] sc;
        logic [DIM_W-1:0]    sat;
        t_bdiv               f;
        f    = r_bs[BDIV_N];
        qadj = {2'b0, f.quo} + (NUM_W+2)'(f.rem != '0);
        qs   = f.neg ? (~qadj + 1'b1) : {2'b0, f.quo};
        sc   = $signed({15'b0, f.s0}) + $signed({qs[NUM_W+1], qs});
        if (f.use_s1) begin
            sat = f.s1;
        end else if (sc[NUM_W+2]) begin
            sat = '0;
        end else if (sc[NUM_W+1:DIM_W] != '0) begin
            sat = '1;
        end else begin
            sat = sc[DIM_W-1:0];
        end
        res.width_new       = f.applied ? sat : f.w;
        res.height_new      = f.applied ? sat : f.h;
        res.segment_applied = f.applied;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= BDIV_N; k++) r_bv[k] <= 1'b0;
        end else if (b_adv) begin
            r_bv[0] <= !i_mid_empty;
            for (int k = 0; k < BDIV_N; k++) r_bv[k+1] <= r_bv[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            for (int k = 0; k <= BDIV_N; k++) r_bs[k] <= n_bs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (oq_push) r_wp <= r_wp + 1'b1;
            if (oq_pop)  r_rp <= r_rp + 1'b1;
            if (oq_push && !oq_pop)      r_cnt <= r_cnt + 1'b1;
            else if (oq_pop && !oq_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) r_oq[r_wp] <= res;
    end

    assign o_width_new       = r_oq[r_rp].width_new;
    assign o_height_new      = r_oq[r_rp].height_new;
    assign o_segment_applied = r_oq[r_rp].segment_applied;

endmodule

/* src/particle_scale_keyframe_interp.sv */
// Keyframed particle scale interpolator.
// Input queue side: drive the particle fields and raise push; a transfer
// happens on a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result sits on the
// o_width_new, o_height_new and o_segment_applied ports; raise pop to take it.
// Keyframes: six 32-bit registers written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata (time Q4.12 in the upper half, scale Q8.8 in the lower half);
// indexes past the last register are dropped. Write only while idle.
// Path: an input transfer runs through the 12-step age divider, the middle
// queue and the 28-step interpolation divider before empty goes low.
// Throughput: one particle per cycle, sustained while pop keeps up.
// When pop stalls, the back pipeline holds once its 4-entry result queue is
// full, the 4-entry middle queue then fills, and full rises when the front
// pipeline cannot move; nothing is lost.
// Reset (synchronous, active low) empties all pipelines and queues and loads
// each keyframe with time K+1.0 and scale 1.0.
module particle_scale_keyframe_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pskf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pskf_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pskf_pkg::LIFE_W-1:0]          i_life_remaining,
    input  logic [pskf_pkg::LIFE_W-1:0]          i_life_total,
    input  logic [pskf_pkg::DIM_W-1:0]           i_width_now,
    input  logic [pskf_pkg::DIM_W-1:0]           i_height_now,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pskf_pkg::DIM_W-1:0]           o_width_new,
    output logic [pskf_pkg::DIM_W-1:0]           o_height_new,
    output logic                                 o_segment_applied
);
    import pskf_pkg::*;

    t_keys r_keys;
    t_mid  mid_in;
    t_mid  mid_out;
    logic  mid_push;
    logic  mid_full;
    logic  mid_pop;
    logic  mid_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) r_keys[k] <= key_rst(k);
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
            r_keys[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    pskf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_keys           (r_keys),
        .i_push           (push),
        .o_full           (full),
        .i_life_remaining (i_life_remaining),
        .i_life_total     (i_life_total),
        .i_width_now      (i_width_now),
        .i_height_now     (i_height_now),
        .o_mid_push       (mid_push),
        .o_mid_data       (mid_in),
        .i_mid_full       (mid_full)
    );

    pskf_midq u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    pskf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mid_data        (mid_out),
        .i_mid_empty       (mid_empty),
        .o_mid_pop         (mid_pop),
        .o_width_new       (o_width_new),
        .o_height_new      (o_height_new),
        .o_segment_applied (o_segment_applied),
        .o_empty           (empty),
        .i_pop             (pop)
    );

endmodule
